### hw/rtl/raf_pkg.sv
`default_nettype none

package raf_pkg;

  // sample and window geometry
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WINDOW  = 32;
  localparam int POS_BITS    = $clog2(MAX_WINDOW);
  localparam int WIN_BITS    = 6;
  localparam int SUM_BITS    = SAMPLE_BITS + POS_BITS;
  localparam int OUT_BITS    = 16;

  // divider steps, one quotient bit each
  localparam int DIV_STEPS   = SUM_BITS;
  localparam int STEP_BITS   = $clog2(DIV_STEPS);

  localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(20);
  localparam logic [WIN_BITS-1:0] WINDOW_MAX   = WIN_BITS'(MAX_WINDOW);
  localparam logic [WIN_BITS-1:0] WINDOW_MIN   = WIN_BITS'(1);

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

### hw/rtl/raf_store.sv
`default_nettype none

module raf_store (
  input  wire logic                            clk,
  input  wire logic                            wr_en,
  input  wire logic [raf_pkg::POS_BITS-1:0]    wr_addr,
  input  wire logic [raf_pkg::SAMPLE_BITS-1:0] wr_data,
  input  wire logic [raf_pkg::POS_BITS-1:0]    rd_addr,
  output logic      [raf_pkg::SAMPLE_BITS-1:0] rd_data
);

  logic [raf_pkg::SAMPLE_BITS-1:0] mem [raf_pkg::MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/raf_divider.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module raf_divider (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [raf_pkg::SUM_BITS-1:0]  dividend,
  input  wire logic [raf_pkg::WIN_BITS-1:0]  divisor,
  output raf_pkg::div_status_t               status,
  output logic      [raf_pkg::SUM_BITS-1:0]  quotient
);

  logic                           busy;
  logic                           done;
  logic [raf_pkg::STEP_BITS-1:0]  step;
  logic [raf_pkg::WIN_BITS-1:0]   rem;
  logic [raf_pkg::WIN_BITS-1:0]   dsr;
  logic [raf_pkg::SUM_BITS-1:0]   quo;
  logic [raf_pkg::WIN_BITS:0]     trial;
  logic                           fits;

  assign trial = {rem, quo[raf_pkg::SUM_BITS-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      if (step == raf_pkg::STEP_BITS'(raf_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= raf_pkg::WIN_BITS'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[raf_pkg::WIN_BITS-1:0];
      end
      quo <= {quo[raf_pkg::SUM_BITS-2:0], fits};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign quotient    = quo;

endmodule

`default_nettype wire

### hw/rtl/running_average_filter.sv
// Running average filter: each accepted sample replaces the oldest of the
// last window_size samples in a 32-entry store, a running sum is updated by
// subtracting the replaced sample and adding the new one, and the result
// item is that sum divided by the number of samples held so far (truncated),
// so the mean is right while the window is still filling. An item passes
// through the store read, the sum update, the restoring divider (one
// quotient bit per cycle, as many bits as the running sum has) and the
// load of the output register, which waits while the output is stalled.
// The block takes one sample at a time; a finished result may wait in the
// output register while the next sample is accepted. A write on the cfg
// channel sets window_size (0 acts as 1, above 32 acts as 32) and clears
// the window, the sum and the held count; it is meant for an idle block.
// Reset sets window_size to 20 and clears the same state. There is no
// clearing pass: entries not yet written in the current window read as zero.
`default_nettype none

module running_average_filter (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // input samples
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [raf_pkg::SAMPLE_BITS-1:0]   s_axis_tdata,  // [15:0] sample
  // averages
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [raf_pkg::OUT_BITS-1:0]      m_axis_tdata,  // [15:0] average
  // window_size register write
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [raf_pkg::WIN_BITS-1:0]      cfg_data
);

  // sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;

  logic [1:0]                        state;
  logic [1:0]                        state_next;

  // filter state
  logic [raf_pkg::WIN_BITS-1:0]      window;      // already clamped to 1..32
  logic [raf_pkg::POS_BITS-1:0]      pos;
  logic [raf_pkg::WIN_BITS-1:0]      held;
  logic [raf_pkg::SUM_BITS-1:0]      sum;
  logic [raf_pkg::SAMPLE_BITS-1:0]   sample;

  logic [raf_pkg::POS_BITS-1:0]      pos_next;
  logic [raf_pkg::WIN_BITS-1:0]      held_next;
  logic [raf_pkg::SUM_BITS-1:0]      sum_next;
  logic [raf_pkg::WIN_BITS-1:0]      window_next;
  logic [raf_pkg::WIN_BITS-1:0]      pos_inc;
  logic [raf_pkg::SAMPLE_BITS-1:0]   old_sample;

  logic                              in_accept;
  logic                              out_accept;
  logic                              cfg_accept;
  logic                              out_free;
  logic                              div_start;
  logic                              out_load;

  logic [raf_pkg::SAMPLE_BITS-1:0]   rd_data;
  raf_pkg::div_status_t              div_status;
  logic [raf_pkg::SUM_BITS-1:0]      quotient;

  assign in_accept  = s_axis_tvalid && s_axis_tready;
  assign out_accept = m_axis_tvalid && m_axis_tready;
  assign cfg_accept = cfg_valid && cfg_ready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // clamp the written window size once, at the write
  always_comb begin
    if (cfg_data == '0) begin
      window_next = raf_pkg::WINDOW_MIN;
    end else if (cfg_data > raf_pkg::WINDOW_MAX) begin
      window_next = raf_pkg::WINDOW_MAX;
    end else begin
      window_next = cfg_data;
    end
  end

  // the slot at pos holds a real sample only once the window has filled
  assign old_sample = (held < window) ? '0 : rd_data;
  assign sum_next   = sum - raf_pkg::SUM_BITS'(old_sample)
                          + raf_pkg::SUM_BITS'(sample);
  assign held_next  = (held < window) ? held + 1'b1 : held;
  assign pos_inc    = raf_pkg::WIN_BITS'(pos) + 1'b1;
  assign pos_next   = (pos_inc >= window) ? '0 : pos_inc[raf_pkg::POS_BITS-1:0];

  assign div_start = (state == S_UPDATE);
  assign out_load  = (state == S_DIV) && div_status.done && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      window <= raf_pkg::WINDOW_RESET;
      pos    <= '0;
      held   <= '0;
      sum    <= '0;
    end else begin
      state <= state_next;
      if (cfg_accept) begin
        window <= window_next;
        pos    <= '0;
        held   <= '0;
        sum    <= '0;
      end else if (div_start) begin
        pos    <= pos_next;
        held   <= held_next;
        sum    <= sum_next;
      end
    end
  end

  // sample payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample <= s_axis_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (out_accept) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= quotient[raf_pkg::OUT_BITS-1:0];
    end
  end

  // store read runs at pos while idle, data is ready in the update cycle
  raf_store u_store (
    .clk     (clk),
    .wr_en   (div_start),
    .wr_addr (pos),
    .wr_data (sample),
    .rd_addr (pos),
    .rd_data (rd_data)
  );

  raf_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (held_next),
    .status   (div_status),
    .quotient (quotient)
  );

`ifndef SYNTHESIS
  a_held_in_window: assert property (@(posedge clk) disable iff (rst)
    held <= window)
    else $error("held count above window size");

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    raf_pkg::WIN_BITS'(pos) < window)
    else $error("write position outside window");

  a_start_idle_divider: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_status.busy)
    else $error("divider started while busy");

  a_result_from_divider: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(div_status.done) && $past(state == S_DIV))
    else $error("result without finished division");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
module tb_top;
  import raf_pkg::*;

  localparam int PHASE_ITEMS = 211;
  localparam int TAIL_CYCLES = 40;

  // tracks the window contents and queues the averages the block owes us
  class moving_average_tracker;
    logic [SAMPLE_BITS-1:0] window_samples [MAX_WINDOW];
    logic [WIN_BITS-1:0]    window_size;
    logic [POS_BITS-1:0]    next_slot;
    logic [WIN_BITS-1:0]    fill;
    logic [SUM_BITS-1:0]    total;
    logic [OUT_BITS-1:0]    pending_averages [$];
    int                     mismatches;

    function new();
      window_size = WINDOW_RESET;
      mismatches  = 0;
      restart();
    endfunction

    function void restart();
      foreach (window_samples[i]) window_samples[i] = '0;
      next_slot = '0;
      fill      = '0;
      total     = '0;
    endfunction

    function void set_window(logic [WIN_BITS-1:0] value);
      window_size = value;
      restart();
    endfunction

    function void take_sample(logic [SAMPLE_BITS-1:0] value);
      int unsigned span;
      int unsigned slot;
      // zero acts as one, anything past the store depth acts as full depth
      span = (window_size == 0) ? 1 :
             ((window_size > MAX_WINDOW) ? MAX_WINDOW : window_size);
      slot = next_slot;
      if (slot >= span) slot = 0;
      total = total - window_samples[slot] + value;
      window_samples[slot] = value;
      slot++;
      if (slot >= span) slot = 0;
      next_slot = POS_BITS'(slot);
      if (fill < span) fill++;
      pending_averages.push_back(OUT_BITS'(total / fill));
    endfunction

    function void match_average(logic [OUT_BITS-1:0] got);
      logic [OUT_BITS-1:0] want;
      if (pending_averages.size() == 0) begin
        $error("average: no item expected, actual %0d", got);
        mismatches++;
      end else begin
        want = pending_averages.pop_front();
        if (got !== want) begin
          $error("average: expected %0d, actual %0d", want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [SAMPLE_BITS-1:0] s_axis_tdata  = '0;  // [15:0] sample
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]    m_axis_tdata;        // [15:0] average
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [WIN_BITS-1:0]    cfg_data      = '0;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;

  moving_average_tracker tracker;

  running_average_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // result side: check on handshake, then pick the next ready level
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) tracker.match_average(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tracker.take_sample(value);
  endtask

  // only written once every owed average has come out
  task automatic write_window(input logic [WIN_BITS-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_averages.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_window(value);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [WIN_BITS-1:0]    phase_windows [9];
    logic [SAMPLE_BITS-1:0] value;
    tracker       = new();
    src_idle_pct  = 8;
    sink_idle_pct = 75;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset window of 20, extremes and bit patterns
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
    send_sample(16'h0001);
    // window zero behaves as one
    write_window('0);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h8000);
    // all ones saturates at full depth
    write_window('1);
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h7FFF);
    write_window(WINDOW_MIN);
    send_sample(16'h00FF);
    send_sample(16'hFF00);
    // small window wraps quickly
    write_window(WIN_BITS'(2));
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0003);
    send_sample(16'h0000);
    // rewriting the same size still empties the window
    write_window(WIN_BITS'(2));
    send_sample(16'hFFFF);

    phase_windows[0] = WINDOW_MAX;
    phase_windows[1] = WIN_BITS'(33);
    phase_windows[2] = WIN_BITS'(2);
    phase_windows[3] = WINDOW_MIN;
    phase_windows[4] = WINDOW_RESET;
    phase_windows[5] = '1;
    phase_windows[6] = '0;
    phase_windows[7] = WIN_BITS'($urandom_range(63, 1));
    phase_windows[8] = WIN_BITS'($urandom_range(31, 3));

    foreach (phase_windows[p]) begin
      // sender light / receiver heavy, then swapped, then no idling
      src_idle_pct  = (p < 3) ? 8  : ((p < 6) ? 75 : 0);
      sink_idle_pct = (p < 3) ? 75 : ((p < 6) ? 8  : 0);
      write_window(phase_windows[p]);
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(7))
          0:       value = 16'hFFFF;
          1:       value = 16'h0000;
          2:       value = SAMPLE_BITS'($urandom_range(15));
          3:       value = 16'hFFFF - SAMPLE_BITS'($urandom_range(15));
          default: value = SAMPLE_BITS'($urandom);
        endcase
        send_sample(value);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (tracker.pending_averages.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_averages.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
